@@ src/template_ncc_matcher_core_defines.svh @@
// assertion macros for the template matcher
`ifndef TEMPLATE_NCC_MATCHER_CORE_DEFINES_SVH
`define TEMPLATE_NCC_MATCHER_CORE_DEFINES_SVH

// condition holds in the same cycle
`define TNCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define TNCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tncc_pkg.sv @@
// types and constants of the template matcher
`timescale 1ns / 1ps
`default_nettype none
package tncc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int MAX_IMAGE_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd3;

  localparam logic MODE_TEMPLATE = 1'b0;
  localparam logic MODE_IMAGE    = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic [9:0]         win_row;
    logic [9:0]         win_col;
    logic               flat_window;
    logic               last_window;
  } out_item_t;

endpackage
`default_nettype wire

@@ src/template_ncc_matcher_core.sv @@
// template matcher by zero-mean normalized cross-correlation
//
// usage: load the template first with items of mode 0 (raster order, rows *
// cols pixels), then feed image pixels with mode 1 in raster order. each
// image pixel that completes a template-sized window yields one result item
// with the signed Q1.15 score, the window's top-left row and column, a flag
// for a flat window and a flag for the last window of the image.
// configuration: cfg_index selects template_rows, template_cols,
// image_width or image_height; write only while the block is idle.
// an image pixel that completes no window is only stored. a completing pixel
// runs a scan with one line store read per template pixel (n = rows * cols),
// a 32-step square root and a 50-step division, all in shared sequential
// units. a template pixel updates the template sums via the multiplier.
// in_ready is high only while the block is idle. the result waits in an
// output register; a stalled receiver holds it there and the next item is
// accepted meanwhile, but a new result waits until the register is free.
// reset (synchronous, active low) clears the sums, the load count, the
// image position and the registers to 8, 8, 640 and 480; stores are not
// cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "template_ncc_matcher_core_defines.svh"
module template_ncc_matcher_core #(
  parameter int MAX_TEMPLATE_ROWS = 16,
  parameter int MAX_TEMPLATE_COLS = 16,
  parameter int MAX_IMAGE_WIDTH   = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire tncc_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output tncc_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tncc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tncc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tncc_pkg::*;

  localparam int LRW = (MAX_TEMPLATE_ROWS > 1) ? $clog2(MAX_TEMPLATE_ROWS) : 1;
  localparam int CW  = $clog2(MAX_IMAGE_WIDTH);
  localparam int LAW = $clog2(MAX_TEMPLATE_ROWS * MAX_IMAGE_WIDTH);
  localparam int LDEPTH = MAX_TEMPLATE_ROWS * MAX_IMAGE_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE, S_TMUL_A, S_TMUL_B, S_TFIN, S_SCAN, S_DRAIN,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
    S_SQRT, S_DIVINIT, S_DIV, S_SAT, S_OUT
  } state_t;

  state_t state_r;

  logic [4:0]  trows_r, tcols_r;
  logic [10:0] iwidth_r, iheight_r;

  logic [8:0]  load_r;
  logic [15:0] tsum_r;
  logic [23:0] traw_r;
  logic [31:0] tsq_r;
  logic [9:0]  row_r;
  logic [CW-1:0]  col_r;
  logic [LRW-1:0] lr_r;

  logic [7:0] tmpl_mem [256];
  logic [7:0] line_mem [LDEPTH];
  logic [7:0] tp_rdata_r, ls_rdata_r;

  logic [LRW-1:0] scan_lr_r;
  logic [4:0]     scan_i_r, scan_j_r;
  logic [7:0]     scan_t_r;
  logic           rd_v_r;
  logic [15:0]    sw_r;
  logic [23:0]    sww_r, stw_r;
  logic [9:0]     top_r;
  logic [CW-1:0]  left_r;
  logic           last_r;

  logic [63:0] mul_p_r;
  logic [31:0] mul_a, mul_b;
  logic [32:0] tmp_r;
  logic signed [34:0] num_r;
  logic [31:0] dw_r;
  logic [63:0] sq_rad_r;
  logic [31:0] sq_root_r;
  logic [35:0] sq_rem_r;
  logic [31:0] d_r;
  logic [49:0] dv_q_r;
  logic [32:0] dv_rem_r;
  logic [5:0]  cnt_r;
  logic signed [15:0] score_r;
  logic        flat_r;
  logic        out_valid_r;
  out_item_t   out_item_r;

  // effective sizes
  logic [4:0]  tr, tc;
  logic [9:0]  n10;
  logic [8:0]  n;
  logic [10:0] iw, ih;

  always_comb begin
    tr = (trows_r == 5'd0) ? 5'd1 :
         (int'(trows_r) > MAX_TEMPLATE_ROWS) ? 5'(MAX_TEMPLATE_ROWS) : trows_r;
    tc = (tcols_r == 5'd0) ? 5'd1 :
         (int'(tcols_r) > MAX_TEMPLATE_COLS) ? 5'(MAX_TEMPLATE_COLS) : tcols_r;
    n10 = 10'(tr) * 10'(tc);
    n   = (n10 > 10'd256) ? 9'd256 : n10[8:0];
    iw  = (iwidth_r == 11'd0) ? 11'd1 :
          (int'(iwidth_r) > MAX_IMAGE_WIDTH) ? 11'(MAX_IMAGE_WIDTH) : iwidth_r;
    ih  = (iheight_r == 11'd0) ? 11'd1 :
          (int'(iheight_r) > MAX_IMAGE_HEIGHT) ? 11'(MAX_IMAGE_HEIGHT) : iheight_r;
  end

  // image position bookkeeping
  logic [11:0] col_inc;
  logic [10:0] row_inc;
  logic [9:0]  row_nxt;
  logic [CW-1:0]  col_nxt;
  logic [LRW-1:0] lr_inc, lr_nxt;
  logic        win_hit;
  logic [LRW-1:0] scan_lr_start;
  logic [7:0]  lr_wide;

  always_comb begin
    col_inc = 12'(col_r) + 12'd1;
    row_inc = 11'(row_r) + 11'd1;
    lr_inc  = (int'(lr_r) == MAX_TEMPLATE_ROWS - 1) ? '0 : LRW'(lr_r + 1'b1);
    col_nxt = CW'(col_inc);
    row_nxt = row_r;
    lr_nxt  = lr_r;
    if (col_inc >= 12'(iw)) begin
      col_nxt = '0;
      if (row_inc >= ih) begin
        row_nxt = '0;
        lr_nxt  = '0;
      end else begin
        row_nxt = row_inc[9:0];
        lr_nxt  = lr_inc;
      end
    end
    win_hit = (load_r == n) && (row_inc >= 11'(tr)) && (col_inc >= 12'(tc));
    lr_wide = (8'(lr_r) >= 8'(tr) - 8'd1) ? 8'(lr_r) - (8'(tr) - 8'd1)
            : 8'(lr_r) + 8'(MAX_TEMPLATE_ROWS) - (8'(tr) - 8'd1);
    scan_lr_start = LRW'(lr_wide);
  end

  // memory addressing
  logic [LAW-1:0] ls_waddr, ls_raddr;
  logic           ls_we, tp_we;
  logic [7:0]     tp_waddr;
  logic           accept;
  logic           restart;

  assign accept   = in_valid && in_ready;
  assign restart  = load_r >= n;
  assign ls_we    = accept && (in_item.mode == MODE_IMAGE);
  assign tp_we    = accept && (in_item.mode == MODE_TEMPLATE);
  assign tp_waddr = restart ? 8'd0 : load_r[7:0];
  assign ls_waddr = LAW'(LAW'(lr_r) * LAW'(MAX_IMAGE_WIDTH) + LAW'(col_r));
  assign ls_raddr = LAW'(LAW'(scan_lr_r) * LAW'(MAX_IMAGE_WIDTH)
                    + LAW'(CW'(left_r + CW'(scan_j_r))));

  always_ff @(posedge clk) begin
    if (ls_we) begin
      line_mem[ls_waddr] <= in_item.pixel;
    end
    ls_rdata_r <= line_mem[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (tp_we) begin
      tmpl_mem[tp_waddr] <= in_item.pixel;
    end
    tp_rdata_r <= tmpl_mem[scan_t_r];
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TMUL_A: begin mul_a = 32'(n);      mul_b = 32'(traw_r); end
      S_TMUL_B: begin mul_a = 32'(tsum_r); mul_b = 32'(tsum_r); end
      S_M1:     begin mul_a = 32'(n);      mul_b = 32'(stw_r);  end
      S_M2:     begin mul_a = 32'(tsum_r); mul_b = 32'(sw_r);   end
      S_M3:     begin mul_a = 32'(n);      mul_b = 32'(sww_r);  end
      S_M4:     begin mul_a = 32'(sw_r);   mul_b = 32'(sw_r);   end
      S_M6:     begin mul_a = tsq_r;       mul_b = dw_r;        end
      default:  begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= 64'(mul_a) * 64'(mul_b);
  end

  // square root and division steps
  logic [35:0] sq_rem_sh, sq_trial;
  logic        sq_ge;
  logic [32:0] dv_rem_sh;
  logic        dv_ge;
  logic signed [33:0] tdiff;
  logic signed [34:0] sdiff;
  logic [34:0] num_abs;
  logic [7:0]  w_px, t_px;

  always_comb begin
    sq_rem_sh = {sq_rem_r[33:0], sq_rad_r[63:62]};
    sq_trial  = {2'b00, sq_root_r, 2'b01};
    sq_ge     = sq_rem_sh >= sq_trial;
    dv_rem_sh = {dv_rem_r[31:0], dv_q_r[49]};
    dv_ge     = dv_rem_sh >= {1'b0, d_r};
    tdiff     = $signed({1'b0, tmp_r}) - $signed({1'b0, mul_p_r[32:0]});
    sdiff     = $signed({2'b00, tmp_r}) - $signed({2'b00, mul_p_r[32:0]});
    num_abs   = num_r[34] ? 35'(-num_r) : 35'(num_r);
    w_px      = ls_rdata_r;
    t_px      = tp_rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      trows_r     <= 5'd8;
      tcols_r     <= 5'd8;
      iwidth_r    <= 11'd640;
      iheight_r   <= 11'd480;
      load_r      <= '0;
      tsum_r      <= '0;
      traw_r      <= '0;
      tsq_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      lr_r        <= '0;
      rd_v_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TEMPLATE_ROWS: trows_r   <= cfg_data[4:0];
          CFG_TEMPLATE_COLS: tcols_r   <= cfg_data[4:0];
          CFG_IMAGE_WIDTH:   iwidth_r  <= cfg_data;
          CFG_IMAGE_HEIGHT:  iheight_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      rd_v_r <= (state_r == S_SCAN);
      if (rd_v_r) begin
        sw_r  <= sw_r + 16'(w_px);
        sww_r <= sww_r + 24'(16'(w_px) * 16'(w_px));
        stw_r <= stw_r + 24'(16'(t_px) * 16'(w_px));
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_item.mode == MODE_TEMPLATE) begin
              load_r  <= (restart ? 9'd0 : load_r) + 9'd1;
              tsum_r  <= (restart ? 16'd0 : tsum_r) + 16'(in_item.pixel);
              traw_r  <= (restart ? 24'd0 : traw_r)
                         + 24'(16'(in_item.pixel) * 16'(in_item.pixel));
              row_r   <= '0;
              col_r   <= '0;
              lr_r    <= '0;
              state_r <= S_TMUL_A;
            end else begin
              row_r <= row_nxt;
              col_r <= col_nxt;
              lr_r  <= lr_nxt;
              if (win_hit) begin
                top_r     <= 10'(row_inc - 11'(tr));
                left_r    <= CW'(col_inc - 12'(tc));
                last_r    <= (row_inc == ih) && (col_inc == 12'(iw));
                scan_lr_r <= scan_lr_start;
                scan_i_r  <= '0;
                scan_j_r  <= '0;
                scan_t_r  <= '0;
                sw_r      <= '0;
                sww_r     <= '0;
                stw_r     <= '0;
                state_r   <= S_SCAN;
              end
            end
          end
        end
        S_TMUL_A: state_r <= S_TMUL_B;
        S_TMUL_B: begin
          tmp_r   <= mul_p_r[32:0];
          state_r <= S_TFIN;
        end
        S_TFIN: begin
          tsq_r   <= tdiff[33] ? 32'd0 : tdiff[31:0];
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          scan_t_r <= scan_t_r + 8'd1;
          if (scan_j_r == tc - 5'd1) begin
            scan_j_r  <= '0;
            scan_i_r  <= scan_i_r + 5'd1;
            scan_lr_r <= (int'(scan_lr_r) == MAX_TEMPLATE_ROWS - 1) ? '0
                         : LRW'(scan_lr_r + 1'b1);
            if (scan_i_r == tr - 5'd1) begin
              state_r <= S_DRAIN;
            end
          end else begin
            scan_j_r <= scan_j_r + 5'd1;
          end
        end
        S_DRAIN: state_r <= S_M1;
        S_M1:    state_r <= S_M2;
        S_M2: begin
          tmp_r   <= mul_p_r[32:0];
          state_r <= S_M3;
        end
        S_M3: begin
          num_r   <= sdiff;
          state_r <= S_M4;
        end
        S_M4: begin
          tmp_r   <= mul_p_r[32:0];
          state_r <= S_M5;
        end
        S_M5: begin
          dw_r    <= tdiff[33] ? 32'd0 : tdiff[31:0];
          state_r <= S_M6;
        end
        S_M6: state_r <= S_M7;
        S_M7: begin
          sq_rad_r  <= mul_p_r;
          sq_root_r <= '0;
          sq_rem_r  <= '0;
          cnt_r     <= '0;
          state_r   <= S_SQRT;
        end
        S_SQRT: begin
          sq_rad_r <= {sq_rad_r[61:0], 2'b00};
          if (sq_ge) begin
            sq_rem_r  <= sq_rem_sh - sq_trial;
            sq_root_r <= {sq_root_r[30:0], 1'b1};
          end else begin
            sq_rem_r  <= sq_rem_sh;
            sq_root_r <= {sq_root_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            state_r <= S_DIVINIT;
          end
        end
        S_DIVINIT: begin
          d_r <= sq_root_r;
          if (sq_root_r == 32'd0) begin
            score_r <= '0;
            flat_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            flat_r   <= 1'b0;
            dv_q_r   <= {num_abs, 15'd0} + 50'(sq_root_r[31:1]);
            dv_rem_r <= '0;
            cnt_r    <= '0;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          dv_rem_r <= dv_ge ? 33'(dv_rem_sh - {1'b0, d_r}) : dv_rem_sh;
          dv_q_r   <= {dv_q_r[48:0], dv_ge};
          cnt_r    <= cnt_r + 6'd1;
          if (cnt_r == 6'd49) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          if (num_r[34]) begin
            score_r <= (dv_q_r > 50'd32768) ? 16'sh8000 : $signed(-dv_q_r[15:0]);
          end else begin
            score_r <= (dv_q_r > 50'd32767) ? 16'sh7fff : $signed(dv_q_r[15:0]);
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_item_r.score       <= score_r;
            out_item_r.win_row     <= top_r;
            out_item_r.win_col     <= 10'(32'(left_r));
            out_item_r.flat_window <= flat_r;
            out_item_r.last_window <= last_r;
            out_valid_r            <= 1'b1;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `TNCC_ASSERT_NEXT(a_scan_holds_pos, state_r == S_SCAN, $stable(row_r) && $stable(col_r), "position moved during window scan")
  `TNCC_ASSERT_NEXT(a_out_waits, state_r == S_OUT && out_valid_r && !out_ready, state_r == S_OUT, "result overwrote a pending item")
  `TNCC_ASSERT_NOW(a_flat_zero, out_valid_r && out_item_r.flat_window, out_item_r.score == 16'sd0, "flat window with nonzero score")
  `TNCC_ASSERT_NOW(a_div_rem, state_r == S_DIV, dv_rem_r < 33'(d_r), "division remainder out of range")

endmodule
`default_nettype wire

@@ tb/template_ncc_matcher_core_tb.sv @@
// testbench of the template matcher: directed and random phases of template and image items checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module template_ncc_matcher_core_tb;
  import tncc_pkg::*;

  localparam int LINE_ROWS  = 16;
  localparam int LINE_WIDTH = 1024;
  localparam int SETTLE     = 400;
  localparam int LIMIT      = 4000000;
  localparam int LONG_HOLD  = 3000;
  localparam int ITEM_GOAL  = 1870;

  typedef enum int {PX_RANDOM, PX_FLAT, PX_BINARY, PX_NARROW, PX_RAMP} px_kind_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TEMPLATE_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  template_ncc_matcher_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [4:0] reg_rows = 5'd8, reg_cols = 5'd8;
  logic [10:0] reg_width = 11'd640, reg_height = 11'd480;
  logic [7:0] tmpl_px [256];
  logic [15:0] tmpl_sum = '0;
  logic [31:0] tmpl_dev = '0, tmpl_raw = '0;
  logic [7:0] line_px [LINE_ROWS*LINE_WIDTH];
  logic [8:0] load_cnt = '0;
  int unsigned cur_row = 0, cur_col = 0;

  out_item_t score_q [$];
  in_item_t pend_q [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  bit no_idle = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned gen_n = 64, gen_load = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void predict_item(in_item_t it);
    int unsigned tr, tc, n, iw, ih, row, col, top, left, lr;
    longint unsigned sw, sww, stw, dmag, a, mag;
    longint num, dw, s, v;
    logic [7:0] w, t;
    out_item_t r;
    tr = clampu(reg_rows, 1, 16);
    tc = clampu(reg_cols, 1, 16);
    n = tr * tc;
    iw = clampu(reg_width, 1, LINE_WIDTH);
    ih = clampu(reg_height, 1, MAX_IMAGE_HEIGHT);
    row = cur_row;
    col = cur_col;
    if (it.mode == MODE_TEMPLATE) begin
      if (load_cnt >= n) begin
        load_cnt = '0;
        tmpl_sum = '0;
        tmpl_raw = '0;
      end
      tmpl_px[load_cnt[7:0]] = it.pixel;
      load_cnt = load_cnt + 9'd1;
      tmpl_sum = tmpl_sum + 16'(it.pixel);
      tmpl_raw = tmpl_raw + 32'(it.pixel) * 32'(it.pixel);
      s = longint'(tmpl_sum);
      v = longint'(n) * longint'(tmpl_raw) - s * s;
      tmpl_dev = (v < 0) ? 32'd0 : 32'(v);
      cur_row = 0;
      cur_col = 0;
      return;
    end
    line_px[(row % LINE_ROWS) * LINE_WIDTH + (col % LINE_WIDTH)] = it.pixel;
    if (load_cnt == n && row + 1 >= tr && col + 1 >= tc) begin
      top = row + 1 - tr;
      left = col + 1 - tc;
      sw = 0; sww = 0; stw = 0;
      for (int i = 0; i < tr; i++) begin
        lr = (top + i) % LINE_ROWS;
        for (int j = 0; j < tc; j++) begin
          w = line_px[lr * LINE_WIDTH + ((left + j) % LINE_WIDTH)];
          t = tmpl_px[(i * tc + j) & 8'hFF];
          sw += w;
          sww += w * w;
          stw += t * w;
        end
      end
      num = longint'(n) * longint'(stw) - longint'(tmpl_sum) * longint'(sw);
      dw = longint'(n) * longint'(sww) - longint'(sw) * longint'(sw);
      if (dw < 0) dw = 0;
      dmag = int_sqrt(longint'(tmpl_dev) * dw);
      r = '0;
      if (dmag == 0) begin
        r.flat_window = 1'b1;
      end else begin
        a = (num < 0 ? -num : num) * 32768;
        mag = (a + dmag / 2) / dmag;
        if (num < 0) r.score = (mag > 32768) ? -16'sd32768 : 16'(-longint'(mag));
        else r.score = (mag > 32767) ? 16'sd32767 : 16'(mag);
      end
      r.win_row = top[9:0];
      r.win_col = left[9:0];
      r.last_window = (row + 1 == ih && col + 1 == iw);
      score_q.push_back(r);
    end
    col++;
    if (col >= iw) begin
      col = 0;
      row++;
      if (row >= ih) row = 0;
    end
    cur_row = row;
    cur_col = col;
  endfunction

  // input driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_item(in_item);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          in_item <= pend_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= rand_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (score_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %p", out_item);
        end else begin
          e = score_q.pop_front();
          if (out_item.score !== e.score || out_item.win_row !== e.win_row ||
              out_item.win_col !== e.win_col || out_item.flat_window !== e.flat_window ||
              out_item.last_window !== e.last_window) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p got %p", e, out_item);
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt >= LONG_HOLD) long_hold_done <= 1'b1;
        out_ready <= (hold_cnt >= LONG_HOLD);
      end else begin
        out_ready <= (rand_gap() == 0);
      end
    end
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TEMPLATE_ROWS: reg_rows = 5'(value);
      CFG_TEMPLATE_COLS: reg_cols = 5'(value);
      CFG_IMAGE_WIDTH:   reg_width = 11'(value);
      default:           reg_height = 11'(value);
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || in_valid || score_q.size() > 0 || !in_ready || out_valid)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] gen_px(px_kind_e kind, int unsigned i, logic [7:0] base);
    case (kind)
      PX_FLAT:   return base;
      PX_BINARY: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      PX_NARROW: return base + 8'($urandom_range(0, 3));
      PX_RAMP:   return base + 8'(i * 7);
      default:   return 8'($urandom);
    endcase
  endfunction

  function automatic void push_item(logic mode, logic [7:0] px);
    in_item_t it;
    it.mode = mode;
    it.pixel = px;
    pend_q.push_back(it);
    items_sent++;
  endfunction

  function automatic void push_tmpl_px(logic [7:0] px);
    if (gen_load >= gen_n) gen_load = 0;
    gen_load++;
    push_item(MODE_TEMPLATE, px);
  endfunction

  function automatic void load_template(px_kind_e kind);
    logic [7:0] base;
    int unsigned i;
    base = 8'($urandom);
    i = 0;
    do begin
      push_tmpl_px(gen_px(kind, i, base));
      i++;
    end while (gen_load != gen_n);
  endfunction

  task automatic run_phase(int unsigned rows, int unsigned cols, int unsigned w, int unsigned h,
                           int unsigned npix, px_kind_e tkind, px_kind_e ikind,
                           bit reload_mid, bit noise);
    logic [7:0] base;
    write_reg(CFG_TEMPLATE_ROWS, rows);
    write_reg(CFG_TEMPLATE_COLS, cols);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    gen_n = clampu(rows & 31, 1, 16) * clampu(cols & 31, 1, 16);
    base = 8'($urandom);
    load_template(tkind);
    for (int unsigned i = 0; i < npix; i++) begin
      if (reload_mid && i == npix / 2) load_template(px_kind_e'($urandom_range(0, 4)));
      if (noise && $urandom_range(0, 9) < 2) push_tmpl_px(8'($urandom));
      else push_item(MODE_IMAGE, gen_px(ikind, i, base));
    end
    wait_idle();
  endtask

  initial begin
    int unsigned r, c, w, h;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed
    run_phase(2, 2, 4, 3, 16, PX_BINARY, PX_BINARY, 0, 0);
    run_phase(2, 3, 3, 3, 9, PX_FLAT, PX_RANDOM, 0, 0);
    run_phase(2, 2, 3, 3, 9, PX_RANDOM, PX_FLAT, 0, 0);
    run_phase(4, 4, 3, 3, 9, PX_RANDOM, PX_RANDOM, 0, 0);
    run_phase(2, 2, 4, 4, 16, PX_RAMP, PX_RAMP, 1, 0);
    run_phase(31, 0, 0, 2047, 20, PX_RANDOM, PX_RANDOM, 0, 0);
    run_phase(1, 1, 2047, 1, 30, PX_RANDOM, PX_NARROW, 0, 0);
    run_phase(16, 16, 16, 16, 256, PX_RANDOM, PX_RANDOM, 0, 0);
    // random phases
    while (items_sent < ITEM_GOAL) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      c = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      w = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 20) : $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      if (!long_hold_req && items_sent > 900) begin
        long_hold_req = 1'b1;
        r = 1;
        c = 1;
        w = 8;
        h = 8;
      end
      run_phase(r, c, w, h, $urandom_range(w * h / 2, w * h * 2 + 4),
                px_kind_e'($urandom_range(0, 9) == 0 ? 1 : $urandom_range(0, 4)),
                px_kind_e'($urandom_range(0, 9) == 0 ? 1 : $urandom_range(0, 4)),
                $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
    end
    if (mismatches == 0 && score_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ template_ncc_matcher_core.f @@
+incdir+src
src/tncc_pkg.sv
src/template_ncc_matcher_core.sv
tb/template_ncc_matcher_core_tb.sv
